// ===== src/ink_color_correction_macros.svh =====
// Assertion macros used by the color correction FIFO.
`ifndef INK_COLOR_CORRECTION_MACROS_SVH
`define INK_COLOR_CORRECTION_MACROS_SVH
`ifndef SYNTHESIS
`define ICC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ICC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ICC_ASSERT(lbl, prop, msg)
`define ICC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/icc_pkg.sv =====
package icc_pkg;

  localparam int unsigned COMPONENT_MAX = 65535;
  localparam int unsigned HLS_SCALE     = 100;
  localparam int unsigned CHAN_DEN      = 60 * HLS_SCALE * HLS_SCALE;

  // floor(x * HLS_SCALE / (2 * COMPONENT_MAX)) == (x * LIGHT_RECIP) >> LIGHT_SHIFT
  // for every lightness sum x up to 2 * COMPONENT_MAX
  localparam int              LIGHT_SHIFT = 31;
  localparam longint unsigned LIGHT_RECIP =
      ((64'd1 << LIGHT_SHIFT) * HLS_SCALE + 2 * COMPONENT_MAX - 1) / (2 * COMPONENT_MAX);

  // floor(x * COMPONENT_MAX / CHAN_DEN) == (x * CHAN_RECIP) >> CHAN_SHIFT
  // for every channel numerator x up to CHAN_DEN
  localparam int              CHAN_SHIFT = 35;
  localparam longint unsigned CHAN_RECIP =
      ((64'd1 << CHAN_SHIFT) * COMPONENT_MAX + CHAN_DEN - 1) / CHAN_DEN;

  localparam int ANCHOR_COUNT = 12;
  localparam int ANCHOR_HUE [ANCHOR_COUNT] =
      '{0, 50, 70, 180, 215, 230, 260, 275, 305, 315, 330, 360};
  localparam int ANCHOR_SHIFT [ANCHOR_COUNT] =
      '{-30, -10, 0, 0, -7, -10, -28, -25, 0, -10, -15, -30};

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] light;
    logic [6:0] sat;
  } icc_hls_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } icc_rgb_t;

endpackage

// ===== src/icc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Requires num_i[NW-1:QW] < den_i.
module icc_div #(
  parameter int NW = 24,
  parameter int DW = 17,
  parameter int QW = 9,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int WW = DW + QW;

  logic [WW-1:0] w_in   [QW];
  logic [DW-1:0] d_in   [QW];
  logic [WW-1:0] work_d [QW];
  logic [WW-1:0] work_q [QW];
  logic [DW-1:0] den_q  [QW-1];
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld_q;

  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] sub;
    logic        ge;
    w_in[0] = {DW'(num_i[NW-1:QW]), num_i[QW-1:0]};
    d_in[0] = den_i;
    for (int i = 1; i < QW; i++) begin
      w_in[i] = work_q[i-1];
      d_in[i] = den_q[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      trial     = w_in[i][WW-1:QW-1];
      sub       = trial - {1'b0, d_in[i]};
      ge        = trial >= {1'b0, d_in[i]};
      work_d[i] = {(ge ? sub[DW-1:0] : trial[DW-1:0]), w_in[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 0; i < QW; i++) begin
        work_q[i] <= work_d[i];
      end
      for (int i = 1; i < QW; i++) begin
        side_q[i] <= side_q[i-1];
      end
      for (int i = 0; i < QW - 1; i++) begin
        den_q[i] <= d_in[i];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = work_q[QW-1][QW-1:0];
  assign side_o  = side_q[QW-1];

endmodule

// ===== src/icc_fifo.sv =====
`include "ink_color_correction_macros.svh"

module icc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CW'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ICC_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH), "fifo count above depth")
  `ICC_ASSERT(a_push_grows, (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1, "fifo count did not grow on push")
  `ICC_ASSERT(a_pop_shrinks, (do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1, "fifo count did not shrink on pop")

endmodule

// ===== src/icc_front.sv =====
// RGB to HLS: sector/extremes, numerators, then two parallel dividers.
module icc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             push_i,
  input  logic [15:0]      red_i,
  input  logic [15:0]      green_i,
  input  logic [15:0]      blue_i,
  output logic             valid_o,
  output icc_pkg::icc_hls_t hls_o
);

  import icc_pkg::*;

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} icc_sector_e;

  logic [15:0]        r, g, b, mx, mn;
  icc_sector_e        sec_d;
  logic signed [16:0] diff_d;

  logic               s1_vld_q;
  logic [15:0]        s1_delta_q;
  logic [16:0]        s1_lsum_q;
  logic signed [16:0] s1_diff_q;
  icc_sector_e        s1_sec_q;

  logic [8:0]         base;
  logic [24:0]        base_mul;
  logic signed [25:0] d60, hue_sum;
  logic [37:0]        lprod;
  logic [6:0]         light_d;
  logic [22:0]        snum_d;
  logic [16:0]        sden_d;
  logic               grey_d;

  logic               s2_vld_q;
  logic [6:0]         s2_light_q;
  logic [22:0]        s2_snum_q;
  logic [16:0]        s2_sden_q;
  logic [24:0]        s2_hnum_q;
  logic [15:0]        s2_hden_q;
  logic               s2_grey_q;

  logic [8:0]         sq, hq, hue_raw;
  logic [7:0]         hue_side;
  logic               grey_out;
  logic [6:0]         light_out;

  always_comb begin
    r  = (red_i   > 16'(COMPONENT_MAX)) ? 16'(COMPONENT_MAX) : red_i;
    g  = (green_i > 16'(COMPONENT_MAX)) ? 16'(COMPONENT_MAX) : green_i;
    b  = (blue_i  > 16'(COMPONENT_MAX)) ? 16'(COMPONENT_MAX) : blue_i;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    // ties: red beats green beats blue
    priority if (r == mx) begin
      sec_d  = SEC_RED;
      diff_d = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (g == mx) begin
      sec_d  = SEC_GREEN;
      diff_d = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      sec_d  = SEC_BLUE;
      diff_d = $signed({1'b0, r}) - $signed({1'b0, g});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= push_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_delta_q <= mx - mn;
      s1_lsum_q  <= {1'b0, mx} + {1'b0, mn};
      s1_diff_q  <= diff_d;
      s1_sec_q   <= sec_d;
    end
  end

  always_comb begin
    unique case (s1_sec_q)
      SEC_RED:   base = 9'd120;
      SEC_GREEN: base = 9'd240;
      default:   base = 9'd360;
    endcase
    base_mul = 25'(base) * 25'(s1_delta_q);
    d60      = 26'(s1_diff_q) * 26'sd60;
    // base*delta + 60*diff never goes negative
    hue_sum  = $signed({1'b0, base_mul}) + d60;
    // lightness divides by a constant: reciprocal multiply
    lprod    = 38'(s1_lsum_q) * 38'(LIGHT_RECIP);
    light_d  = lprod[LIGHT_SHIFT+6:LIGHT_SHIFT];
    snum_d   = 23'(s1_delta_q) * 23'(HLS_SCALE);
    sden_d   = (s1_lsum_q <= 17'(COMPONENT_MAX)) ? s1_lsum_q
                                                 : 17'(2 * COMPONENT_MAX) - s1_lsum_q;
    grey_d   = (26'(s1_delta_q) * 26'(1000)) < 26'(COMPONENT_MAX);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_light_q <= light_d;
      s2_snum_q  <= snum_d;
      s2_sden_q  <= sden_d;
      s2_hnum_q  <= hue_sum[24:0];
      s2_hden_q  <= s1_delta_q;
      s2_grey_q  <= grey_d;
    end
  end

  icc_div #(.NW(23), .DW(17), .QW(9), .SW(1)) u_div_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s2_vld_q),
    .num_i   (s2_snum_q),
    .den_i   (s2_sden_q),
    .side_i  (1'b0),
    .valid_o (),
    .quo_o   (sq),
    .side_o  ()
  );

  // lightness rides along the hue divider to stay aligned
  icc_div #(.NW(25), .DW(16), .QW(9), .SW(8)) u_div_hue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (s2_vld_q),
    .num_i   (s2_hnum_q),
    .den_i   (s2_hden_q),
    .side_i  ({s2_grey_q, s2_light_q}),
    .valid_o (valid_o),
    .quo_o   (hq),
    .side_o  (hue_side)
  );

  assign grey_out  = hue_side[7];
  assign light_out = hue_side[6:0];

  // grey results from the dividers are garbage; forced to zero here
  assign hue_raw     = (hq > 9'd360) ? hq - 9'd360 : hq;
  assign hls_o.hue   = grey_out ? '0 : hue_raw;
  assign hls_o.light = light_out;
  assign hls_o.sat   = grey_out ? '0 : sq[6:0];

endmodule

// ===== src/icc_back.sv =====
// Hue shift, lightening and HLS to RGB.
module icc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  icc_pkg::icc_hls_t hls_i,
  output logic              valid_o,
  output icc_pkg::icc_rgb_t rgb_o
);

  import icc_pkg::*;

  function automatic logic [5:0] ramp(logic [8:0] a);
    priority if (a < 9'd60) begin
      return a[5:0];
    end else if (a < 9'd180) begin
      return 6'd60;
    end else if (a < 9'd240) begin
      return 6'(9'd240 - a);
    end else begin
      return 6'd0;
    end
  endfunction

  // segment lookup
  logic [3:0]        seg;
  logic signed [6:0] slope_d;
  logic signed [12:0] off_d;
  logic [6:0]        t_d;
  logic [7:0]        den_d;

  logic              b1_vld_q;
  logic signed [6:0] b1_slope_q;
  logic signed [12:0] b1_off_q;
  logic [6:0]        b1_t_q;
  logic [7:0]        b1_den_q;
  icc_hls_t          b1_hls_q;

  logic signed [13:0] num;
  logic              b2_vld_q;
  logic [12:0]       b2_mag_q;
  logic              b2_neg_q;
  logic [7:0]        b2_den_q;
  icc_hls_t          b2_hls_q;

  logic              sh_vld;
  logic [5:0]        sh_q;
  logic [23:0]       sh_side;
  icc_hls_t          sh_hls;
  logic              sh_neg;

  logic signed [9:0] hue2;
  logic [8:0]        hue3, h, a0, a2, dist240, dist300;
  logic [4:0]        bump240, bump300;
  logic [7:0]        lsum;
  logic [6:0]        lvl_d, sat_d;

  logic              b3_vld_q;
  logic [6:0]        b3_l_q, b3_s_q;
  logic [5:0]        b3_t_q [3];

  logic [13:0]       n1_d, n2_d;
  logic              b4_vld_q;
  logic [13:0]       b4_n1_q, b4_n2_q;
  logic [5:0]        b4_t_q [3];

  logic              b5_vld_q;
  logic [19:0]       b5_num_q [3];
  logic [51:0]       chan_prod [3];
  logic              b6_vld_q;
  logic [15:0]       b6_rgb_q [3];

  always_comb begin
    logic found;
    int   h1, h2, s1, s2, d;
    found = 1'b0;
    seg   = '0;
    for (int i = 0; i < ANCHOR_COUNT - 1; i++) begin
      if (!found && int'(hls_i.hue) >= ANCHOR_HUE[i] &&
          int'(hls_i.hue) <= ANCHOR_HUE[i+1]) begin
        found = 1'b1;
        seg   = 4'(i);
      end
    end
    h1      = ANCHOR_HUE[seg];
    h2      = ANCHOR_HUE[4'(seg + 1'b1)];
    s1      = ANCHOR_SHIFT[seg];
    s2      = ANCHOR_SHIFT[4'(seg + 1'b1)];
    d       = h2 - h1;
    slope_d = 7'(2 * (s2 - s1));
    off_d   = 13'(d * (2 * s1 + 1));
    t_d     = 7'(int'(hls_i.hue) - h1);
    den_d   = 8'(2 * d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
      b4_vld_q <= 1'b0;
      b5_vld_q <= 1'b0;
      b6_vld_q <= 1'b0;
    end else if (en_i) begin
      b1_vld_q <= valid_i;
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= sh_vld;
      b4_vld_q <= b3_vld_q;
      b5_vld_q <= b4_vld_q;
      b6_vld_q <= b5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_slope_q <= slope_d;
      b1_off_q   <= off_d;
      b1_t_q     <= t_d;
      b1_den_q   <= den_d;
      b1_hls_q   <= hls_i;
    end
  end

  // shift numerator; division truncates toward zero, so split off the sign
  assign num = 14'(b1_off_q) + 14'(b1_slope_q) * $signed({7'b0, b1_t_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b2_neg_q <= num[13];
      b2_mag_q <= num[13] ? 13'(-num) : 13'(num);
      b2_den_q <= b1_den_q;
      b2_hls_q <= b1_hls_q;
    end
  end

  icc_div #(.NW(13), .DW(8), .QW(6), .SW(24)) u_div_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (b2_vld_q),
    .num_i   (b2_mag_q),
    .den_i   (b2_den_q),
    .side_i  ({b2_neg_q, b2_hls_q}),
    .valid_o (sh_vld),
    .quo_o   (sh_q),
    .side_o  (sh_side)
  );

  assign sh_neg = sh_side[23];
  assign sh_hls = sh_side[22:0];

  always_comb begin
    hue2 = sh_neg ? $signed({1'b0, sh_hls.hue}) - $signed({4'b0, sh_q})
                  : $signed({1'b0, sh_hls.hue}) + $signed({4'b0, sh_q});
    priority if (hue2 < 0) begin
      hue3 = 9'(hue2 + 10'sd360);
    end else if (hue2 > 10'sd360) begin
      hue3 = 9'(hue2 - 10'sd360);
    end else begin
      hue3 = hue2[8:0];
    end
    dist240 = (hue3 >= 9'd240) ? hue3 - 9'd240 : 9'd240 - hue3;
    dist300 = (hue3 >= 9'd300) ? hue3 - 9'd300 : 9'd300 - hue3;
    bump240 = (hue3 > 9'd200 && hue3 < 9'd280) ? 5'((6'd40 - 6'(dist240)) >> 1) : '0;
    bump300 = (hue3 > 9'd260 && hue3 < 9'd340) ? 5'((6'd40 - 6'(dist300)) >> 1) : '0;
    lsum    = {1'b0, sh_hls.light} + 8'(bump240) + 8'(bump300);
    lvl_d   = (lsum > 8'(HLS_SCALE)) ? 7'(HLS_SCALE) : lsum[6:0];
    sat_d   = (sh_hls.sat > 7'(HLS_SCALE)) ? 7'(HLS_SCALE) : sh_hls.sat;
    h       = (hue3 < 9'd120) ? hue3 + 9'd240 : hue3 - 9'd120;
    a0      = (h > 9'd240) ? h - 9'd240 : h + 9'd120;
    a2      = (h < 9'd120) ? h + 9'd240 : h - 9'd120;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b3_l_q    <= lvl_d;
      b3_s_q    <= sat_d;
      b3_t_q[0] <= ramp(a0);
      b3_t_q[1] <= ramp(h);
      b3_t_q[2] <= ramp(a2);
    end
  end

  always_comb begin
    int l, s;
    l = int'(b3_l_q);
    s = int'(b3_s_q);
    priority if (s * 1000 < int'(HLS_SCALE)) begin
      // grey: every channel comes out as lightness at full scale
      n2_d = 14'(l * int'(HLS_SCALE));
      n1_d = n2_d;
    end else if (2 * l <= int'(HLS_SCALE)) begin
      n2_d = 14'(l * (int'(HLS_SCALE) + s));
      n1_d = '0;
    end else begin
      n2_d = 14'(l * int'(HLS_SCALE) + s * int'(HLS_SCALE) - l * s);
      n1_d = 14'(2 * l * int'(HLS_SCALE) - l * int'(HLS_SCALE) - s * int'(HLS_SCALE) + l * s);
    end
  end

  // scale to full range and divide by CHAN_DEN in one reciprocal multiply
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      chan_prod[c] = 52'(b5_num_q[c]) * 52'(CHAN_RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b4_n1_q <= n1_d;
      b4_n2_q <= n2_d;
      b4_t_q  <= b3_t_q;
      for (int c = 0; c < 3; c++) begin
        b5_num_q[c] <= 20'(b4_n1_q) * 20'(60) +
                       20'(b4_n2_q - b4_n1_q) * 20'(b4_t_q[c]);
        b6_rgb_q[c] <= chan_prod[c][CHAN_SHIFT+15:CHAN_SHIFT];
      end
    end
  end

  assign valid_o     = b6_vld_q;
  assign rgb_o.red   = b6_rgb_q[0];
  assign rgb_o.green = b6_rgb_q[1];
  assign rgb_o.blue  = b6_rgb_q[2];

endmodule

// ===== src/ink_color_correction.sv =====
// Ink color correction: converts each RGB pixel to HLS, shifts the hue over
// a fixed anchor table, lightens hues near 240 and 300, and converts back to
// RGB. Both sides are queues: push a pixel while full is low, pop a result
// while empty is low; results come out in push order. The block takes one
// pixel per clock for as long as results are popped. With no stall a result
// passes through the front pipeline (two setup stages and a 9-stage divider),
// the middle queue, the back pipeline (a 6-stage hue-shift divider and six
// arithmetic stages) and the output queue before it is poppable. MID_DEPTH and
// OUT_DEPTH size the two queues.
module ink_color_correction #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] red_out_o,
  output logic [15:0] green_out_o,
  output logic [15:0] blue_out_o
);

  import icc_pkg::*;

  logic     front_valid, mid_full, mid_empty, mid_pop;
  logic     back_en, back_valid, out_full;
  icc_hls_t front_hls, mid_hls;
  icc_rgb_t back_rgb, out_rgb;

  assign full    = mid_full;
  assign back_en = !out_full;
  assign mid_pop = back_en && !mid_empty;

  icc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (!mid_full),
    .push_i  (push),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .valid_o (front_valid),
    .hls_o   (front_hls)
  );

  icc_fifo #(.WIDTH($bits(icc_hls_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_hls),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_hls),
    .empty_o (mid_empty)
  );

  icc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (back_en),
    .valid_i (mid_pop),
    .hls_i   (mid_hls),
    .valid_o (back_valid),
    .rgb_o   (back_rgb)
  );

  icc_fifo #(.WIDTH($bits(icc_rgb_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .data_i  (back_rgb),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rgb),
    .empty_o (empty)
  );

  assign red_out_o   = out_rgb.red;
  assign green_out_o = out_rgb.green;
  assign blue_out_o  = out_rgb.blue;

endmodule
